// ===== sv/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock, disabled in reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Assert a property on the rising clock, always active
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/tpgl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgl_pkg
// Shared types and constants for the two-pass gradient limiter.
// ----------------------------------------------------------------------------
package tpgl_pkg;
    localparam int FieldW    = 42;
    localparam int StepW     = 34;
    localparam int NumFields = 5;
    localparam int MaxLenDef = 64;
    localparam int ProdW     = 2 * FieldW;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_STORE,
        ST_FWD_RD,
        ST_FWD_CMP,
        ST_BWD_RD,
        ST_BWD_CMP,
        ST_SCALE_RD,
        ST_SCALE_MUL,
        ST_SCALE_DIV,
        ST_SCALE_WR,
        ST_OUT_RD,
        ST_OUT_HOLD
    } state_t;
endpackage

// ===== sv/two_pass_gradient_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-pass gradient limiter
// Buffers one line of samples, limits S velocity rise in a forward then a
// backward pass, rescales the other fields, and streams the line back out.
// ----------------------------------------------------------------------------
// Channel   | Direction | Contents
// s_axis    | in        | one sample; tuser = end_of_line
// m_axis    | out       | graded sample; tuser = {last_of_run, was_changed}
// cfg       | in        | max_step write
//
// Loading a sample is the transaction, then one memory word per field with
// s_axis_tready low. After the end-of-line transaction each neighbour check
// is a read then a compare; a changed sample puts each of its five fields
// through a read, shift-add multiply, restoring divide and write on the shared
// unit. Output reads each sample's words; m_axis stalls simply hold output.
// Synchronous active-low reset clears control state, not the sample memory.
`include "assert_macros.svh"

module two_pass_gradient_limiter #(
    parameter int MAX_LEN = tpgl_pkg::MaxLenDef
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [41:0] p_velocity, [83:42] s_velocity, [125:84] density_in,
    // [167:126] qp_in, [209:168] qs_in, [215:210] zero
    input  logic [215:0]                s_axis_tdata,
    // [0] end_of_line
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [41:0] p_velocity_out, [83:42] s_velocity_out, [125:84] density_out,
    // [167:126] qp_out, [209:168] qs_out, [215:210] zero
    output logic [215:0]                m_axis_tdata,
    // [0] was_changed, [1] last_of_run
    output logic [1:0]                  m_axis_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tpgl_pkg::StepW-1:0]  cfg_data
);
    localparam int FW  = tpgl_pkg::FieldW;
    localparam int NF  = tpgl_pkg::NumFields;
    localparam int PW  = tpgl_pkg::ProdW;
    localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int AW  = $clog2(MAX_LEN * NF);
    localparam int KW  = $clog2(PW + 1);
    localparam int DEP = MAX_LEN * NF;

    // one word per field; address = sample * NF + field
    logic [FW-1:0] mem [DEP];
    logic [FW-1:0] rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [FW-1:0] wr_data;

    tpgl_pkg::state_t state_reg, state_next;

    logic [tpgl_pkg::StepW-1:0] max_step_reg;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [IW-1:0]  idx_reg, idx_next;     // sample being limited / output
    logic [IW-1:0]  nb_reg, nb_next;       // neighbour
    logic [2:0]     fld_reg, fld_next;
    logic [FW-1:0]  vs_reg, vs_next;       // old S velocity (divisor)
    logic [FW-1:0]  nv_reg, nv_next;       // new S velocity
    logic [FW-1:0]  tmp_reg, tmp_next;     // first read word, then multiplicand
    logic [FW-1:0]  mpl_reg, mpl_next;     // multiplier, MSB first
    logic           rd_phase_reg, rd_phase_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [FW:0]    rem_reg, rem_next;
    logic [FW-1:0]  quo_reg, quo_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [MAX_LEN-1:0] chg_reg, chg_next;
    logic           bwd_reg, bwd_next;
    logic [FW*NF-1:0] obuf_reg, obuf_next;
    logic [FW*NF-1:0] inbuf_reg, inbuf_next;
    logic           eol_reg, eol_next;
    logic [FW:0]    trial;
    logic [FW:0]    rem_sh;
    logic [FW:0]    lim_sum;
    logic           over;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] s, input logic [2:0] f);
        logic [AW+2:0] a;
        a = AW'(s) * (AW+3)'(NF) + (AW+3)'(f);
        return a[AW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tpgl_pkg::ST_LOAD;
            max_step_reg <= '0;
            fill_reg     <= '0;
            chg_reg      <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            chg_reg   <= chg_next;
            if (cfg_valid && cfg_ready) begin
                max_step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        nb_reg       <= nb_next;
        fld_reg      <= fld_next;
        vs_reg       <= vs_next;
        nv_reg       <= nv_next;
        tmp_reg      <= tmp_next;
        mpl_reg      <= mpl_next;
        rd_phase_reg <= rd_phase_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        k_reg        <= k_next;
        bwd_reg      <= bwd_next;
        obuf_reg     <= obuf_next;
        inbuf_reg    <= inbuf_next;
        eol_reg      <= eol_next;
    end

    assign cfg_ready = 1'b1;
    assign rem_sh  = {rem_reg[FW-1:0], prod_reg[PW-1]};
    assign trial   = rem_sh - {1'b0, vs_reg};
    assign lim_sum = {1'b0, rd_data} + (FW+1)'(max_step_reg);
    assign over    = (tmp_reg > rd_data) &&
                     ((tmp_reg - rd_data) > FW'(max_step_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tpgl_pkg::ST_LOAD: begin
                if (s_axis_tvalid) begin
                    if (fill_reg != CW'(MAX_LEN)) begin
                        state_next = tpgl_pkg::ST_STORE;
                    end else if (s_axis_tuser) begin
                        state_next = tpgl_pkg::ST_FWD_RD;
                    end
                end
            end
            tpgl_pkg::ST_STORE: begin
                if (fld_reg == 3'(NF - 1)) begin
                    if (!eol_reg) begin
                        state_next = tpgl_pkg::ST_LOAD;
                    end else begin
                        state_next = (fill_reg == '0) ? tpgl_pkg::ST_OUT_RD
                                                      : tpgl_pkg::ST_FWD_RD;
                    end
                end
            end
            tpgl_pkg::ST_FWD_RD, tpgl_pkg::ST_BWD_RD: begin
                if (rd_phase_reg) begin
                    state_next = (state_reg == tpgl_pkg::ST_FWD_RD) ?
                                 tpgl_pkg::ST_FWD_CMP : tpgl_pkg::ST_BWD_CMP;
                end
            end
            tpgl_pkg::ST_FWD_CMP, tpgl_pkg::ST_BWD_CMP: begin
                if (over) begin
                    state_next = tpgl_pkg::ST_SCALE_RD;
                end else if (state_reg == tpgl_pkg::ST_FWD_CMP) begin
                    state_next = (CW'(idx_reg) + CW'(1) == fill_reg) ?
                                 tpgl_pkg::ST_BWD_RD : tpgl_pkg::ST_FWD_RD;
                end else begin
                    state_next = (idx_reg == '0) ? tpgl_pkg::ST_OUT_RD
                                                 : tpgl_pkg::ST_BWD_RD;
                end
            end
            tpgl_pkg::ST_SCALE_RD: begin
                if (rd_phase_reg) begin
                    state_next = tpgl_pkg::ST_SCALE_MUL;
                end
            end
            tpgl_pkg::ST_SCALE_MUL: begin
                if (k_reg == KW'(1)) begin
                    state_next = tpgl_pkg::ST_SCALE_DIV;
                end
            end
            tpgl_pkg::ST_SCALE_DIV: begin
                if (k_reg == KW'(1)) begin
                    state_next = tpgl_pkg::ST_SCALE_WR;
                end
            end
            tpgl_pkg::ST_SCALE_WR: begin
                if (fld_reg == 3'(NF - 1)) begin
                    if (!bwd_reg) begin
                        state_next = (CW'(idx_reg) + CW'(1) == fill_reg) ?
                                     tpgl_pkg::ST_BWD_RD : tpgl_pkg::ST_FWD_RD;
                    end else begin
                        state_next = (idx_reg == '0) ? tpgl_pkg::ST_OUT_RD
                                                     : tpgl_pkg::ST_BWD_RD;
                    end
                end else begin
                    state_next = tpgl_pkg::ST_SCALE_RD;
                end
            end
            tpgl_pkg::ST_OUT_RD: begin
                if (fld_reg == 3'(NF)) begin
                    state_next = tpgl_pkg::ST_OUT_HOLD;
                end
            end
            tpgl_pkg::ST_OUT_HOLD: begin
                if (m_axis_tready) begin
                    state_next = (CW'(idx_reg) + CW'(1) == fill_reg) ?
                                 tpgl_pkg::ST_LOAD : tpgl_pkg::ST_OUT_RD;
                end
            end
            default: state_next = tpgl_pkg::ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        nb_next       = nb_reg;
        fld_next      = fld_reg;
        vs_next       = vs_reg;
        nv_next       = nv_reg;
        tmp_next      = tmp_reg;
        mpl_next      = mpl_reg;
        rd_phase_next = 1'b0;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        k_next        = k_reg;
        chg_next      = chg_reg;
        bwd_next      = bwd_reg;
        obuf_next     = obuf_reg;
        inbuf_next    = inbuf_reg;
        eol_next      = eol_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            tpgl_pkg::ST_LOAD: begin
                s_axis_tready = 1'b1;
                fld_next      = '0;
                if (s_axis_tvalid) begin
                    inbuf_next = s_axis_tdata[FW*NF-1:0];
                    eol_next   = s_axis_tuser;
                    // line full: sample dropped, grading still runs on end of line
                    if (fill_reg == CW'(MAX_LEN) && s_axis_tuser) begin
                        chg_next = '0;
                        bwd_next = 1'b0;
                        idx_next = IW'(1);
                        nb_next  = '0;
                    end
                end
            end
            tpgl_pkg::ST_STORE: begin
                // one field word a cycle, lowest field first
                wr_en      = 1'b1;
                wr_addr    = addr_of(IW'(fill_reg), fld_reg);
                wr_data    = inbuf_reg[FW-1:0];
                inbuf_next = {FW'(0), inbuf_reg[FW*NF-1:FW]};
                fld_next   = fld_reg + 3'd1;
                if (fld_reg == 3'(NF - 1)) begin
                    fld_next  = '0;
                    fill_next = fill_reg + CW'(1);
                    if (eol_reg) begin
                        chg_next = '0;
                        bwd_next = 1'b0;
                        nb_next  = '0;
                        idx_next = (fill_reg == '0) ? '0 : IW'(1);
                    end
                end
            end
            tpgl_pkg::ST_FWD_RD, tpgl_pkg::ST_BWD_RD: begin
                bwd_next = (state_reg == tpgl_pkg::ST_BWD_RD);
                if (!rd_phase_reg) begin
                    if (state_reg == tpgl_pkg::ST_BWD_RD && !bwd_reg) begin
                        // entering backward pass from the last sample
                        idx_next = IW'(fill_reg - CW'(2));
                        nb_next  = IW'(fill_reg - CW'(1));
                        rd_addr  = addr_of(IW'(fill_reg - CW'(2)), 3'd1);
                    end else begin
                        rd_addr  = addr_of(idx_reg, 3'd1);
                    end
                    rd_phase_next = 1'b1;
                end else begin
                    tmp_next = rd_data;
                    rd_addr  = addr_of(nb_reg, 3'd1);
                end
            end
            tpgl_pkg::ST_FWD_CMP, tpgl_pkg::ST_BWD_CMP: begin
                fld_next = '0;
                if (over) begin
                    vs_next = tmp_reg;
                    nv_next = lim_sum[FW-1:0];
                    chg_next[idx_reg] = 1'b1;
                end else if (state_reg == tpgl_pkg::ST_FWD_CMP) begin
                    nb_next  = idx_reg;
                    idx_next = idx_reg + IW'(1);
                end else if (idx_reg != '0) begin
                    nb_next  = idx_reg;
                    idx_next = idx_reg - IW'(1);
                end
            end
            tpgl_pkg::ST_SCALE_RD: begin
                rd_addr = addr_of(idx_reg, fld_reg);
                rd_phase_next = !rd_phase_reg;
                if (rd_phase_reg) begin
                    tmp_next  = rd_data;
                    mpl_next  = nv_reg;
                    prod_next = '0;
                    k_next    = KW'(FW);
                end
            end
            tpgl_pkg::ST_SCALE_MUL: begin
                // shift-add multiply, one multiplier bit a cycle
                prod_next = {prod_reg[PW-2:0], 1'b0} +
                            (mpl_reg[FW-1] ? PW'(tmp_reg) : PW'(0));
                mpl_next  = {mpl_reg[FW-2:0], 1'b0};
                k_next    = k_reg - KW'(1);
                if (k_reg == KW'(1)) begin
                    rem_next = '0;
                    quo_next = '0;
                    k_next   = KW'(PW);
                end
            end
            tpgl_pkg::ST_SCALE_DIV: begin
                // restoring division, one quotient bit a cycle
                prod_next = {prod_reg[PW-2:0], 1'b0};
                k_next    = k_reg - KW'(1);
                if (!trial[FW]) begin
                    rem_next = trial;
                    quo_next = {quo_reg[FW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[FW-2:0], 1'b0};
                end
            end
            tpgl_pkg::ST_SCALE_WR: begin
                wr_en    = 1'b1;
                wr_addr  = addr_of(idx_reg, fld_reg);
                wr_data  = (fld_reg == 3'd1) ? nv_reg : quo_reg;
                fld_next = fld_reg + 3'd1;
                if (fld_reg == 3'(NF - 1)) begin
                    fld_next = '0;
                    if (!bwd_reg) begin
                        nb_next  = idx_reg;
                        idx_next = idx_reg + IW'(1);
                    end else if (idx_reg != '0) begin
                        nb_next  = idx_reg;
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            tpgl_pkg::ST_OUT_RD: begin
                if (fld_reg != 3'(NF)) begin
                    rd_addr = addr_of(idx_reg, fld_reg);
                end
                fld_next = fld_reg + 3'd1;
                if (fld_reg != '0) begin
                    obuf_next = {rd_data, obuf_reg[FW*NF-1:FW]};
                end
            end
            tpgl_pkg::ST_OUT_HOLD: begin
                m_axis_tvalid = 1'b1;
                fld_next      = '0;
                if (m_axis_tready) begin
                    idx_next = idx_reg + IW'(1);
                    if (CW'(idx_reg) + CW'(1) == fill_reg) begin
                        fill_next = '0;
                    end
                end
            end
            default: ;
        endcase
        if (state_reg == tpgl_pkg::ST_OUT_HOLD && m_axis_tready &&
            CW'(idx_reg) + CW'(1) == fill_reg) begin
            idx_next = '0;
        end
    end

    assign m_axis_tdata = {6'd0, obuf_reg};
    assign m_axis_tuser = {(CW'(idx_reg) + CW'(1) == fill_reg), chg_reg[idx_reg]};

    `ASSERT_CLK(a_no_out_in_load, aclk, aresetn,
        (state_reg == tpgl_pkg::ST_LOAD) |-> !m_axis_tvalid, "output while loading")
    `ASSERT_CLK(a_fill_bound, aclk, aresetn,
        fill_reg <= CW'(MAX_LEN), "fill count beyond capacity")
    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "output changed")
endmodule
